### rtl/core/gdph_pkg.sv
// Shared types and constants for the gizmo drag plane hit pipeline.
package gdph_pkg;

	typedef enum logic [1:0] {
		OP_MOVE_X = 2'd0,
		OP_MOVE_Y = 2'd1,
		OP_MOVE_Z = 2'd2,
		OP_ROTATE = 2'd3
	} op_t;

	localparam logic [1:0] CFG_PARALLEL_LIMIT = 2'd0;
	localparam logic [1:0] CFG_MIN_DISTANCE   = 2'd1;

	localparam logic [30:0] PARALLEL_LIMIT_RST = 31'd1074;
	localparam logic [16:0] MIN_DISTANCE_RST   = 17'd66;

	localparam logic signed [31:0] DIR_ONE    = 32'sh4000_0000;
	localparam logic [34:0]        OFFSET_CAP = 35'h4_0000_0000;

	// index 0 = x, 1 = y, 2 = z
	typedef struct packed {
		op_t              op;
		logic [2:0][31:0] org;
		logic [2:0][31:0] dir;
		logic [2:0][31:0] piv;
	} geom_t;

	typedef struct packed {
		geom_t       g;
		logic [30:0] ax;
		logic [30:0] az;
		logic        neg_x;
		logic        neg_z;
		logic        halved;
	} norm_req_t;

	typedef struct packed {
		geom_t g;
		logic  neg_x;
	} norm_side_t;

	typedef struct packed {
		logic [2:0][31:0] org;
		logic [2:0][31:0] dir;
		logic [2:0][31:0] piv;
		logic             hit;
	} ray_t;

endpackage

### rtl/core/gdph_isqrt_pipe.sv
// Pipelined ceiling square root, one result bit per stage, with sideband carried along.
module gdph_isqrt_pipe #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [63:0]   radicand,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [31:0]   root,
	output logic [SW-1:0] out_side
);
	localparam int STEPS = 32;

	logic          vld_s  [1:STEPS];
	logic [31:0]   root_s [1:STEPS];
	logic [34:0]   rem_s  [1:STEPS];
	logic [63:0]   rad_s  [1:STEPS];
	logic [SW-1:0] side_s [1:STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic          vld_c;
		logic [31:0]   root_c;
		logic [34:0]   rem_c;
		logic [63:0]   rad_c;
		logic [SW-1:0] side_c;
		logic [34:0]   acc;
		logic [34:0]   trial;

		if (i == 0) begin : g_first
			assign vld_c  = in_valid;
			assign root_c = '0;
			assign rem_c  = '0;
			assign rad_c  = radicand;
			assign side_c = in_side;
		end else begin : g_next
			assign vld_c  = vld_s[i];
			assign root_c = root_s[i];
			assign rem_c  = rem_s[i];
			assign rad_c  = rad_s[i];
			assign side_c = side_s[i];
		end

		// remainder never exceeds 2*root, so its top bits are always zero
		assign acc   = {rem_c[32:0], rad_c[63:62]};
		assign trial = {1'b0, root_c, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (acc >= trial) begin
					rem_s[i+1]  <= acc - trial;
					root_s[i+1] <= {root_c[30:0], 1'b1};
				end else begin
					rem_s[i+1]  <= acc;
					root_s[i+1] <= {root_c[30:0], 1'b0};
				end
				rad_s[i+1]  <= {rad_c[61:0], 2'b00};
				side_s[i+1] <= side_c;
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign root      = root_s[STEPS] + 32'(rem_s[STEPS] != '0);
	assign out_side  = side_s[STEPS];

endmodule

### rtl/core/gdph_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage; needs dividend >> QW below divisor.
module gdph_div_pipe #(
	parameter int DW = 63,
	parameter int VW = 32,
	parameter int QW = 63,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] quotient,
	output logic [SW-1:0] out_side
);
	logic [VW+DW-1:0] dvd_ext;

	logic          vld_s [1:QW];
	logic [VW-1:0] rem_s [1:QW];
	logic [QW-1:0] low_s [1:QW];
	logic [QW-1:0] quo_s [1:QW];
	logic [VW-1:0] div_s [1:QW];
	logic [SW-1:0] side_s [1:QW];

	assign dvd_ext = {{VW{1'b0}}, dividend};

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic          vld_c;
		logic [VW-1:0] rem_c;
		logic [QW-1:0] low_c;
		logic [QW-1:0] quo_c;
		logic [VW-1:0] div_c;
		logic [SW-1:0] side_c;
		logic [VW:0]   acc;

		if (i == 0) begin : g_first
			assign vld_c  = in_valid;
			assign rem_c  = dvd_ext[QW+VW-1:QW];
			assign low_c  = dividend[QW-1:0];
			assign quo_c  = '0;
			assign div_c  = divisor;
			assign side_c = in_side;
		end else begin : g_next
			assign vld_c  = vld_s[i];
			assign rem_c  = rem_s[i];
			assign low_c  = low_s[i];
			assign quo_c  = quo_s[i];
			assign div_c  = div_s[i];
			assign side_c = side_s[i];
		end

		assign acc = {rem_c, low_c[QW-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (acc >= {1'b0, div_c}) begin
					rem_s[i+1] <= VW'(acc - {1'b0, div_c});
					quo_s[i+1] <= {quo_c[QW-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= acc[VW-1:0];
					quo_s[i+1] <= {quo_c[QW-2:0], 1'b0};
				end
				low_s[i+1]  <= {low_c[QW-2:0], 1'b0};
				div_s[i+1]  <= div_c;
				side_s[i+1] <= side_c;
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quotient  = quo_s[QW];
	assign out_side  = side_s[QW];

endmodule

### rtl/core/gizmo_drag_plane_hit.sv
// Top level: streaming ray/plane intersection for gizmo dragging.
// One query is taken every clock cycle while the output is not stalled, and results leave
// in order. The pipeline is built from the bit-per-stage units: a 32-stage square root
// and 31-stage dividers for the camera-facing normal, then a 63-stage divider for the ray
// parameter t, plus twelve local stages. A stall on the output freezes the whole
// pipeline; no query is dropped. Configuration writes are taken at any time but must only
// be issued while no query is in flight.
module gizmo_drag_plane_hit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic signed [31:0] pivot_x,
	input  logic signed [31:0] pivot_y,
	input  logic signed [31:0] pivot_z,
	input  logic signed [31:0] camera_x,
	input  logic signed [31:0] camera_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic               hit
);
	import gdph_pkg::*;

	logic [30:0] parallel_limit_q;
	logic [16:0] min_distance_q;
	logic        en;

	// s1: input register
	logic               vld_s1;
	geom_t              geom_s1;
	logic signed [31:0] camx_s1, camz_s1;

	// s2: horizontal offset magnitudes
	logic               vld_s2;
	norm_req_t          req_s2;
	logic signed [32:0] offx, offz;
	logic [32:0]        magx, magz;
	logic               big;

	// s3, s4: squares and their sum
	logic               vld_s3, vld_s4;
	norm_req_t          req_s3, req_s4;
	logic [61:0]        sqx_s3, sqz_s3;
	logic [63:0]        rad_s4;

	// square root
	logic               sq_vld;
	logic [31:0]        sq_root;
	norm_req_t          sq_req;

	// s5: length with floor
	logic               vld_s5;
	norm_req_t          req_s5;
	logic [31:0]        len_s5;
	logic [16:0]        floor_len;
	logic [31:0]        len_c;

	// normal dividers
	logic               nx_vld;
	logic [30:0]        nx_quo, nz_quo;
	norm_side_t         nx_side;
	logic               nz_neg;

	// s6: normal and pivot-origin difference
	logic               vld_s6;
	geom_t              geom_s6;
	logic signed [31:0] nrm_s6 [3];
	logic signed [32:0] dif_s6 [3];

	// s7: products
	logic               vld_s7;
	geom_t              geom_s7;
	logic signed [63:0] dprod_s7 [3];
	logic signed [64:0] nprod_s7 [3];

	// s8: dot products
	logic               vld_s8;
	geom_t              geom_s8;
	logic signed [65:0] den_s8;
	logic signed [66:0] num_s8;

	// s9: magnitudes and hit decision
	logic               vld_s9;
	ray_t               ray_s9;
	logic [31:0]        dmag_s9;
	logic [62:0]        nmag_s9;
	logic [65:0]        den_abs;
	logic [66:0]        num_abs;
	logic [31:0]        dmag_c;

	// t divider
	logic               t_vld;
	logic [62:0]        t_quo;
	ray_t               t_ray;

	// s10: partial products of t*|dir|
	logic               vld_s10;
	ray_t               ray_s10;
	logic [63:0]        plo_s10 [3];
	logic [62:0]        phi_s10 [3];

	// s11: capped offsets
	logic               vld_s11;
	ray_t               ray_s11;
	logic [34:0]        off_s11 [3];

	// s12: output register
	logic               vld_s12;
	logic [2:0][31:0]   pt_s12;
	logic               hit_s12;

	assign en        = !vld_s12 || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parallel_limit_q <= PARALLEL_LIMIT_RST;
			min_distance_q   <= MIN_DISTANCE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PARALLEL_LIMIT: parallel_limit_q <= cfg_data[30:0];
				CFG_MIN_DISTANCE:   min_distance_q   <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// valid chain of the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= sq_vld;
			vld_s6  <= nx_vld;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= t_vld;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	// s1
	always_ff @(posedge clk) begin
		if (en) begin
			geom_s1.op  <= op_t'(operation);
			geom_s1.org <= {origin_z, origin_y, origin_x};
			geom_s1.dir <= {dir_z, dir_y, dir_x};
			geom_s1.piv <= {pivot_z, pivot_y, pivot_x};
			camx_s1     <= camera_x;
			camz_s1     <= camera_z;
		end
	end

	// s2: halve both when either offset reaches 2^31
	always_comb begin
		offx = 33'(camx_s1) - 33'($signed(geom_s1.piv[0]));
		offz = 33'(camz_s1) - 33'($signed(geom_s1.piv[2]));
		magx = offx[32] ? 33'(-offx) : 33'(offx);
		magz = offz[32] ? 33'(-offz) : 33'(offz);
		big  = (magx[32:31] != 2'b00) || (magz[32:31] != 2'b00);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s2.g      <= geom_s1;
			req_s2.ax     <= big ? magx[31:1] : magx[30:0];
			req_s2.az     <= big ? magz[31:1] : magz[30:0];
			req_s2.neg_x  <= offx[32];
			req_s2.neg_z  <= offz[32];
			req_s2.halved <= big;
		end
	end

	// s3, s4
	always_ff @(posedge clk) begin
		if (en) begin
			req_s3 <= req_s2;
			sqx_s3 <= 62'(req_s2.ax) * 62'(req_s2.ax);
			sqz_s3 <= 62'(req_s2.az) * 62'(req_s2.az);
			req_s4 <= req_s3;
			rad_s4 <= 64'(sqx_s3) + 64'(sqz_s3);
		end
	end

	gdph_isqrt_pipe #(
		.SW($bits(norm_req_t))
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s4),
		.radicand (rad_s4),
		.in_side  (req_s4),
		.out_valid(sq_vld),
		.root     (sq_root),
		.out_side (sq_req)
	);

	// s5: a zero floor acts as one; no floor when the offsets were halved
	always_comb begin
		floor_len = (min_distance_q == '0) ? 17'd1 : min_distance_q;
		len_c     = sq_root;
		if (!sq_req.halved && sq_root < 32'(floor_len)) begin
			len_c = 32'(floor_len);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s5 <= sq_req;
			len_s5 <= len_c;
		end
	end

	gdph_div_pipe #(
		.DW(61),
		.VW(32),
		.QW(31),
		.SW($bits(norm_side_t))
	) u_div_nx (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s5),
		.dividend ({req_s5.ax, 30'd0}),
		.divisor  (len_s5),
		.in_side  ({req_s5.g, req_s5.neg_x}),
		.out_valid(nx_vld),
		.quotient (nx_quo),
		.out_side (nx_side)
	);

	gdph_div_pipe #(
		.DW(61),
		.VW(32),
		.QW(31),
		.SW(1)
	) u_div_nz (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s5),
		.dividend ({req_s5.az, 30'd0}),
		.divisor  (len_s5),
		.in_side  (req_s5.neg_z),
		.out_valid(),
		.quotient (nz_quo),
		.out_side (nz_neg)
	);

	// s6
	always_ff @(posedge clk) begin
		if (en) begin
			geom_s6 <= nx_side.g;
			if (nx_side.g.op == OP_MOVE_Y) begin
				nrm_s6[0] <= nx_side.neg_x ? -$signed({1'b0, nx_quo}) : $signed({1'b0, nx_quo});
				nrm_s6[1] <= '0;
				nrm_s6[2] <= nz_neg ? -$signed({1'b0, nz_quo}) : $signed({1'b0, nz_quo});
			end else begin
				nrm_s6[0] <= '0;
				nrm_s6[1] <= DIR_ONE;
				nrm_s6[2] <= '0;
			end
			for (int k = 0; k < 3; k++) begin
				dif_s6[k] <= 33'($signed(nx_side.g.piv[k])) - 33'($signed(nx_side.g.org[k]));
			end
		end
	end

	// s7
	always_ff @(posedge clk) begin
		if (en) begin
			geom_s7 <= geom_s6;
			for (int k = 0; k < 3; k++) begin
				dprod_s7[k] <= 64'(nrm_s6[k]) * 64'($signed(geom_s6.dir[k]));
				nprod_s7[k] <= 65'(nrm_s6[k]) * 65'(dif_s6[k]);
			end
		end
	end

	// s8
	always_ff @(posedge clk) begin
		if (en) begin
			geom_s8 <= geom_s7;
			den_s8  <= 66'(dprod_s7[0]) + 66'(dprod_s7[1]) + 66'(dprod_s7[2]);
			num_s8  <= 67'(nprod_s7[0]) + 67'(nprod_s7[1]) + 67'(nprod_s7[2]);
		end
	end

	// s9: |den| stays below 2^62 and |num| below 2^63
	always_comb begin
		den_abs = den_s8[65] ? 66'(-den_s8) : 66'(den_s8);
		num_abs = num_s8[66] ? 67'(-num_s8) : 67'(num_s8);
		dmag_c  = den_abs[61:30];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s9.org <= geom_s8.org;
			ray_s9.dir <= geom_s8.dir;
			ray_s9.piv <= geom_s8.piv;
			ray_s9.hit <= !(dmag_c == '0 || dmag_c < 32'(parallel_limit_q) ||
				num_s8 == '0 || (num_s8[66] != den_s8[65]));
			dmag_s9    <= dmag_c;
			nmag_s9    <= num_abs[62:0];
		end
	end

	gdph_div_pipe #(
		.DW(63),
		.VW(32),
		.QW(63),
		.SW($bits(ray_t))
	) u_div_t (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s9),
		.dividend (nmag_s9),
		.divisor  (dmag_s9),
		.in_side  (ray_s9),
		.out_valid(t_vld),
		.quotient (t_quo),
		.out_side (t_ray)
	);

	// s10: t*|dir| split into low and high halves of t
	always_ff @(posedge clk) begin
		if (en) begin
			ray_s10 <= t_ray;
			for (int k = 0; k < 3; k++) begin
				plo_s10[k] <= 64'(t_quo[31:0]) * 64'(t_ray.dir[k][31] ?
					32'(-t_ray.dir[k]) : t_ray.dir[k]);
				phi_s10[k] <= 63'(t_quo[62:32]) * 63'(t_ray.dir[k][31] ?
					32'(-t_ray.dir[k]) : t_ray.dir[k]);
			end
		end
	end

	// s11: shift down by 30 and cap
	always_ff @(posedge clk) begin
		if (en) begin
			ray_s11 <= ray_s10;
			for (int k = 0; k < 3; k++) begin
				if (phi_s10[k][62:32] != '0) begin
					off_s11[k] <= OFFSET_CAP;
				end else if (({1'b0, phi_s10[k][31:0], 2'b00} + 35'(plo_s10[k][63:30]))
					> OFFSET_CAP) begin
					off_s11[k] <= OFFSET_CAP;
				end else begin
					off_s11[k] <= {1'b0, phi_s10[k][31:0], 2'b00} + 35'(plo_s10[k][63:30]);
				end
			end
		end
	end

	// s12: apply sign, add origin, saturate; on a miss the pivot is passed through
	always_ff @(posedge clk) begin
		logic signed [36:0] sum;
		if (en) begin
			hit_s12 <= ray_s11.hit;
			for (int k = 0; k < 3; k++) begin
				sum = 37'($signed(ray_s11.org[k])) + (ray_s11.dir[k][31] ?
					-$signed({2'b00, off_s11[k]}) : $signed({2'b00, off_s11[k]}));
				if (!ray_s11.hit) begin
					pt_s12[k] <= ray_s11.piv[k];
				end else if (sum > 37'sd2147483647) begin
					pt_s12[k] <= 32'h7FFF_FFFF;
				end else if (sum < -37'sd2147483648) begin
					pt_s12[k] <= 32'h8000_0000;
				end else begin
					pt_s12[k] <= sum[31:0];
				end
			end
		end
	end

	assign out_valid = vld_s12;
	assign point_x   = pt_s12[0];
	assign point_y   = pt_s12[1];
	assign point_z   = pt_s12[2];
	assign hit       = hit_s12;

endmodule
